// ----- hdl/bafl_pkg.sv -----
// Shared types and constants for the arena bump allocator with free list.
package bafl_pkg;

   // Arena geometry
   localparam int ARENA_BYTES = 4096;
   localparam int ADDR_W      = 12;
   localparam int CAP_W       = 13;
   localparam int LINK_W      = ADDR_W + 1;
   localparam int LINK_DEPTH  = 1 << ADDR_W;

   // Stream payload widths (padded to whole bytes)
   localparam int REQ_W = 32;
   localparam int RSP_W = 32;

   // Configuration register indexes
   localparam logic REG_ARENA_CAPACITY = 1'b0;
   localparam logic REG_SLOT_SIZE      = 1'b1;

   // Request commands
   typedef enum logic [2:0] {
      CMD_ALLOC_BYTES   = 3'd0,
      CMD_RELEASE_BYTES = 3'd1,
      CMD_MARK          = 3'd2,
      CMD_RESTORE       = 3'd3,
      CMD_SLOT_ALLOC    = 3'd4,
      CMD_SLOT_FREE     = 3'd5
   } cmd_type;

   // Operations on the bump position
   typedef enum logic [2:0] {
      BUMP_HOLD,
      BUMP_ALLOC,
      BUMP_SLOT,
      BUMP_RELEASE,
      BUMP_RESTORE
   } bump_op_type;

   typedef struct packed {
      logic                en;
      bump_op_type         op;
      logic [CAP_W-1:0]    amount;
      logic [ADDR_W-1:0]   position;
   } bump_cmd_type;

   typedef struct packed {
      logic                granted;
      logic [ADDR_W-1:0]   address;
      logic [ADDR_W-1:0]   used_bytes;
   } bump_rsp_type;

   typedef struct packed {
      logic                we;
      logic                index;
      logic [CAP_W-1:0]    wdata;
   } csr_wr_type;

   typedef enum logic {
      ST_IDLE,
      ST_LINK
   } state_type;

endpackage

// ----- hdl/bafl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bafl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/bafl_bump.sv -----
// Bump position register, configuration registers and the bump arithmetic.
module bafl_bump (
   input  logic                  clock,
   input  logic                  reset,
   input  bafl_pkg::csr_wr_type  csr,
   input  bafl_pkg::bump_cmd_type cmd,
   output bafl_pkg::bump_rsp_type rsp
);

   logic [bafl_pkg::CAP_W-1:0]  cap_ff, cap_in;
   logic [bafl_pkg::ADDR_W-1:0] slot_ff, slot_in;
   logic [bafl_pkg::ADDR_W-1:0] pos_ff, pos_in;

   logic [bafl_pkg::CAP_W-1:0]  cap_eff;
   logic [bafl_pkg::CAP_W-1:0]  take_len;
   logic [bafl_pkg::CAP_W:0]    take_end;
   logic                        take_ok;

   // Configuration writes
   always_comb begin
      cap_in  = cap_ff;
      slot_in = slot_ff;
      if (csr.we) begin
         case (csr.index)
            bafl_pkg::REG_ARENA_CAPACITY: cap_in  = csr.wdata;
            bafl_pkg::REG_SLOT_SIZE:      slot_in = csr.wdata[bafl_pkg::ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   // Capacity clipped to the arena; allocation must end strictly below it
   always_comb begin
      cap_eff  = (cap_ff > bafl_pkg::CAP_W'(bafl_pkg::ARENA_BYTES)) ?
                 bafl_pkg::CAP_W'(bafl_pkg::ARENA_BYTES) : cap_ff;
      take_len = (cmd.op == bafl_pkg::BUMP_SLOT) ? {1'b0, slot_ff} : cmd.amount;
      take_end = {2'b00, pos_ff} + {1'b0, take_len};
      take_ok  = take_end < {1'b0, cap_eff};
   end

   // Next position and result
   always_comb begin
      pos_in         = pos_ff;
      rsp.granted    = 1'b0;
      rsp.address    = '0;
      case (cmd.op)
         bafl_pkg::BUMP_ALLOC, bafl_pkg::BUMP_SLOT: begin
            if (take_ok) begin
               rsp.granted = 1'b1;
               rsp.address = pos_ff;
               pos_in      = take_end[bafl_pkg::ADDR_W-1:0];
            end
         end
         bafl_pkg::BUMP_RELEASE: begin
            // saturate at zero
            if (cmd.amount > {1'b0, pos_ff}) begin
               pos_in = '0;
            end else begin
               pos_in = pos_ff - cmd.amount[bafl_pkg::ADDR_W-1:0];
            end
         end
         bafl_pkg::BUMP_RESTORE: pos_in = cmd.position;
         default: ;
      endcase
      rsp.used_bytes = pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= bafl_pkg::CAP_W'(4096);
         slot_ff <= bafl_pkg::ADDR_W'(24);
         pos_ff  <= '0;
      end else begin
         cap_ff  <= cap_in;
         slot_ff <= slot_in;
         if (cmd.en) begin
            pos_ff <= pos_in;
         end
      end
   end

endmodule

// ----- hdl/bump_allocator_with_free_list_unit.sv -----
// Top level: request sequencing, free-list head and link memory, result register.
// Result: registered in the cycle after the request is accepted; a slot allocation
//   served from the free list is registered only after the ST_LINK link memory read.
// Throughput: one request per cycle while the result register is empty or drained;
//   requests are held off during ST_LINK for slot allocations from the free list.
// Reset: synchronous, active high; clears position, free-list head, result valid
//   and restores capacity 4096, slot size 24. Link RAM is not cleared.
module bump_allocator_with_free_list_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] cmd, [15:3] amount, [27:16] position, [31:28] zero
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] granted, [12:1] address, [13] from_free_list, [25:14] used_bytes, [31:26] zero
   output logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [12:0] csr_wdata
);

   localparam int AW = bafl_pkg::ADDR_W;

   bafl_pkg::state_type    state_ff, state_in;
   logic [AW-1:0]          head_ff, head_in;
   logic                   nonempty_ff, nonempty_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [25:0]            rsp_data_ff, rsp_data_in;

   logic                   req_fire;
   bafl_pkg::cmd_type      req_cmd;
   logic [bafl_pkg::CAP_W-1:0] req_amount;
   logic [AW-1:0]          req_position;

   bafl_pkg::csr_wr_type   csr;
   bafl_pkg::bump_cmd_type bcmd;
   bafl_pkg::bump_rsp_type brsp;

   logic                   ram_wr_en;
   logic [bafl_pkg::LINK_W-1:0] ram_wr_data;
   logic                   ram_rd_en;
   logic [bafl_pkg::LINK_W-1:0] ram_rd_data;

   assign req_cmd      = bafl_pkg::cmd_type'(req_tdata[2:0]);
   assign req_amount   = req_tdata[15:3];
   assign req_position = req_tdata[27:16];
   assign req_tready   = !reset && (state_ff == bafl_pkg::ST_IDLE) &&
                         (!rsp_valid_ff || rsp_tready);
   assign req_fire     = req_tvalid && req_tready;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   bafl_bump u_bump (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cmd   (bcmd),
      .rsp   (brsp)
   );

   bafl_ram #(
      .WIDTH (bafl_pkg::LINK_W),
      .DEPTH (bafl_pkg::LINK_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_position),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // Sequencer, free-list update and result capture
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      nonempty_in   = nonempty_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      bcmd.en       = 1'b0;
      bcmd.op       = bafl_pkg::BUMP_HOLD;
      bcmd.amount   = req_amount;
      bcmd.position = req_position;
      ram_wr_en     = 1'b0;
      ram_wr_data   = {nonempty_ff, head_ff};
      ram_rd_en     = 1'b0;

      case (state_ff)
         bafl_pkg::ST_IDLE: begin
            if (req_fire) begin
               bcmd.en = 1'b1;
               case (req_cmd)
                  bafl_pkg::CMD_ALLOC_BYTES:   bcmd.op = bafl_pkg::BUMP_ALLOC;
                  bafl_pkg::CMD_RELEASE_BYTES: bcmd.op = bafl_pkg::BUMP_RELEASE;
                  bafl_pkg::CMD_RESTORE:       bcmd.op = bafl_pkg::BUMP_RESTORE;
                  bafl_pkg::CMD_SLOT_ALLOC: begin
                     if (!nonempty_ff) bcmd.op = bafl_pkg::BUMP_SLOT;
                  end
                  bafl_pkg::CMD_SLOT_FREE: begin
                     // push: old head becomes the link of the freed slot
                     ram_wr_en   = 1'b1;
                     head_in     = req_position;
                     nonempty_in = 1'b1;
                  end
                  default: ;
               endcase

               if (req_cmd == bafl_pkg::CMD_SLOT_ALLOC && nonempty_ff) begin
                  // pop: fetch successor of the head
                  ram_rd_en = 1'b1;
                  state_in  = bafl_pkg::ST_LINK;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {brsp.used_bytes, 1'b0, brsp.address, brsp.granted};
               end
            end
         end
         bafl_pkg::ST_LINK: begin
            head_in      = ram_rd_data[AW-1:0];
            nonempty_in  = ram_rd_data[AW];
            rsp_valid_in = 1'b1;
            rsp_data_in  = {brsp.used_bytes, 1'b1, head_ff, 1'b1};
            state_in     = bafl_pkg::ST_IDLE;
         end
         default: state_in = bafl_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bafl_pkg::ST_IDLE;
         head_ff      <= '0;
         nonempty_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_data_ff};

endmodule

// ----- hdl/bafl_checker.sv -----
// Port-level checks for the allocator, bound to the top level.
module bafl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Every new result follows an accepted request, directly or through the link read
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready) ||
                            $past(req_tvalid && req_tready, 2))
      else $error("result without request");

   // A refused request carries a zero address
   a_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[12:1] == 12'd0)
      else $error("address set on refused request");

   // Free-list service implies a grant
   a_list_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[13] |-> rsp_tdata[0])
      else $error("free-list result without grant");

endmodule

bind bump_allocator_with_free_list_unit bafl_checker u_bafl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- bench/tb_bump_allocator_with_free_list_unit.sv -----
// Self-checking bench for the arena bump allocator: directed table, random traffic, CSR phases.
`timescale 1ns / 1ps

module tb_bump_allocator_with_free_list_unit;
   import bafl_pkg::*;

   // Spare command codes with no defined action
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 260;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 4;

   // One result as the block reports it
   typedef struct packed {
      logic              granted;
      logic [ADDR_W-1:0] address;
      logic              from_list;
      logic [ADDR_W-1:0] used;
   } arena_result_t;

   // Directed table row; want is only used where typed is set
   typedef struct {
      logic [2:0]        cmd;
      logic [CAP_W-1:0]  amount;
      logic [ADDR_W-1:0] position;
      bit                typed;
      arena_result_t     want;
   } probe_row_t;

   localparam int PROBE_ROWS = 25;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [2:0] cmd, [15:3] amount, [27:16] position, [31:28] zero
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [0] granted, [12:1] address, [13] from_free_list, [25:14] used_bytes, [31:26] zero
   logic [31:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic        csr_index  = REG_ARENA_CAPACITY;
   logic [12:0] csr_wdata  = '0;

   // Predictor state
   logic [CAP_W-1:0]  cap_reg   = 13'd4096;
   logic [ADDR_W-1:0] slot_reg  = 12'd24;
   logic [ADDR_W-1:0] bump_pos  = '0;
   logic [ADDR_W-1:0] free_head = '0;
   logic              free_live = 1'b0;
   logic [LINK_W-1:0] link_mem [LINK_DEPTH];

   // Stimulus bookkeeping
   int                list_refs [LINK_DEPTH];
   logic [ADDR_W-1:0] live_slots [$];
   logic [ADDR_W-1:0] saved_mark = '0;
   arena_result_t     owed_results [$];
   int                mismatches = 0;
   int                cycles     = 0;
   bit                calm       = 1'b0;
   bit                hold_req   = 1'b0;

   probe_row_t probe_rows [PROBE_ROWS] = '{
      '{CMD_MARK,          13'd0,    12'd0,    1'b1, '{1'b0, 12'd0,    1'b0, 12'd0}},
      '{CMD_SLOT_ALLOC,    13'd8191, 12'd4095, 1'b1, '{1'b1, 12'd0,    1'b0, 12'd24}},
      '{CMD_ALLOC_BYTES,   13'd100,  12'd0,    1'b1, '{1'b1, 12'd24,   1'b0, 12'd124}},
      '{CMD_ALLOC_BYTES,   13'd4096, 12'd0,    1'b1, '{1'b0, 12'd0,    1'b0, 12'd124}},
      '{CMD_ALLOC_BYTES,   13'd8191, 12'd4095, 1'b1, '{1'b0, 12'd0,    1'b0, 12'd124}},
      '{CMD_RELEASE_BYTES, 13'd24,   12'd0,    1'b1, '{1'b0, 12'd0,    1'b0, 12'd100}},
      '{CMD_RELEASE_BYTES, 13'd8191, 12'd0,    1'b1, '{1'b0, 12'd0,    1'b0, 12'd0}},
      '{CMD_RESTORE,       13'd8191, 12'd4095, 1'b1, '{1'b0, 12'd0,    1'b0, 12'd4095}},
      '{CMD_ALLOC_BYTES,   13'd0,    12'd0,    1'b1, '{1'b1, 12'd4095, 1'b0, 12'd4095}},
      '{CMD_ALLOC_BYTES,   13'd1,    12'd0,    1'b1, '{1'b0, 12'd0,    1'b0, 12'd4095}},
      '{CMD_SLOT_ALLOC,    13'd0,    12'd0,    1'b1, '{1'b0, 12'd0,    1'b0, 12'd4095}},
      '{CMD_RESTORE,       13'd0,    12'd0,    1'b1, '{1'b0, 12'd0,    1'b0, 12'd0}},
      '{CMD_SLOT_FREE,     13'd0,    12'd4095, 1'b1, '{1'b0, 12'd0,    1'b0, 12'd0}},
      '{CMD_SLOT_FREE,     13'd0,    12'd0,    1'b1, '{1'b0, 12'd0,    1'b0, 12'd0}},
      '{CMD_SLOT_ALLOC,    13'd0,    12'd0,    1'b1, '{1'b1, 12'd0,    1'b1, 12'd0}},
      '{CMD_SLOT_ALLOC,    13'd0,    12'd0,    1'b1, '{1'b1, 12'd4095, 1'b1, 12'd0}},
      '{CMD_SLOT_ALLOC,    13'd0,    12'd0,    1'b1, '{1'b1, 12'd0,    1'b0, 12'd24}},
      '{CMD_SPARE_6,       13'd8191, 12'd4095, 1'b1, '{1'b0, 12'd0,    1'b0, 12'd24}},
      '{CMD_SPARE_7,       13'd0,    12'd0,    1'b1, '{1'b0, 12'd0,    1'b0, 12'd24}},
      '{CMD_SLOT_FREE,     13'd0,    12'd1234, 1'b0, '0},
      '{CMD_SLOT_FREE,     13'd0,    12'd2047, 1'b0, '0},
      '{CMD_SLOT_ALLOC,    13'd0,    12'd0,    1'b0, '0},
      '{CMD_ALLOC_BYTES,   13'd4071, 12'd0,    1'b0, '0},
      '{CMD_SLOT_ALLOC,    13'd0,    12'd0,    1'b0, '0},
      '{CMD_RELEASE_BYTES, 13'd4095, 12'd0,    1'b0, '0}
   };

   bump_allocator_with_free_list_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Advance the arena model by one request and return what the block should report
   function automatic arena_result_t arena_step(input logic [2:0]        c,
                                                input logic [CAP_W-1:0]  amt,
                                                input logic [ADDR_W-1:0] p);
      arena_result_t     r;
      logic [13:0]       ceiling;
      logic [13:0]       reach;
      logic [LINK_W-1:0] link;
      r = '0;
      ceiling = (cap_reg > ARENA_BYTES) ? 14'(ARENA_BYTES) : {1'b0, cap_reg};
      case (c)
         CMD_ALLOC_BYTES: begin
            reach = {2'b0, bump_pos} + {1'b0, amt};
            if (reach < ceiling) begin
               r.granted = 1'b1;
               r.address = bump_pos;
               bump_pos  = reach[ADDR_W-1:0];
            end
         end
         CMD_RELEASE_BYTES: begin
            bump_pos = (amt > bump_pos) ? '0 : bump_pos - amt[ADDR_W-1:0];
         end
         CMD_RESTORE: begin
            bump_pos = p;
         end
         CMD_SLOT_ALLOC: begin
            if (free_live) begin
               link        = link_mem[free_head];
               r.granted   = 1'b1;
               r.from_list = 1'b1;
               r.address   = free_head;
               list_refs[free_head]--;
               free_head   = link[ADDR_W-1:0];
               free_live   = link[ADDR_W];
            end else begin
               reach = {2'b0, bump_pos} + {2'b0, slot_reg};
               if (reach < ceiling) begin
                  r.granted = 1'b1;
                  r.address = bump_pos;
                  bump_pos  = reach[ADDR_W-1:0];
               end
            end
         end
         CMD_SLOT_FREE: begin
            link_mem[p] = {free_live, free_head};
            free_head   = p;
            free_live   = 1'b1;
            list_refs[p]++;
         end
         default: ;
      endcase
      r.used = bump_pos;
      return r;
   endfunction

   // Offer one request, wait for the handshake, then queue the expected result
   task automatic send_request(input logic [2:0]        c,
                               input logic [CAP_W-1:0]  amt,
                               input logic [ADDR_W-1:0] p,
                               input bit                typed,
                               input arena_result_t     want);
      arena_result_t got;
      int            gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, p, amt, c};
      do @(posedge clock); while (!req_tready);
      got = arena_step(c, amt, p);
      owed_results.push_back(typed ? want : got);
      if (c == CMD_SLOT_ALLOC && got.granted)
         live_slots.push_back(got.address);
      if (c == CMD_MARK)
         saved_mark = got.used;
      // sender gap
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Mostly sensible allocator traffic, with junk in unused fields and some noise
   task automatic random_request(input bit allow_double);
      int                w;
      int                k;
      logic [2:0]        c;
      logic [CAP_W-1:0]  amt;
      logic [ADDR_W-1:0] p;
      logic [ADDR_W-1:0] a;
      amt = $urandom_range(0, 8191);
      p   = $urandom_range(0, 4095);
      w   = $urandom_range(0, 99);
      k   = $urandom_range(0, 9);
      if (w < 38) begin
         c = (w < 25) ? CMD_ALLOC_BYTES : CMD_RELEASE_BYTES;
         if (k < 7)
            amt = $urandom_range(0, 64);
         else if (k < 9)
            amt = $urandom_range(0, 4096);
      end else if (w < 45) begin
         c = CMD_MARK;
      end else if (w < 52) begin
         c = CMD_RESTORE;
         if (k < 7)
            p = saved_mark;
      end else if (w < 72) begin
         c = CMD_SLOT_ALLOC;
      end else if (w < 90) begin
         // free a slot handed out earlier
         if (live_slots.size() == 0) begin
            c = CMD_SLOT_ALLOC;
         end else begin
            k = $urandom_range(0, live_slots.size() - 1);
            a = live_slots[k];
            live_slots.delete(k);
            c = (list_refs[a] == 0 || allow_double) ? CMD_SLOT_FREE : CMD_MARK;
            p = a;
         end
      end else if (w < 95) begin
         // free of an arbitrary address; a repeat push loops the list for good
         a = p;
         if (allow_double && free_live && $urandom_range(0, 1) == 0)
            a = free_head;
         c = (list_refs[a] == 0 || allow_double) ? CMD_SLOT_FREE : CMD_MARK;
         p = a;
      end else begin
         c = ($urandom_range(0, 1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
      end
      send_request(c, amt, p, 1'b0, '0);
   endtask

   // Let every owed result arrive, then give the block time to settle
   task automatic drain();
      while (owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int n, input int hold_at, input bit allow_double);
      for (int i = 0; i < n; i++) begin
         if (i == hold_at)
            hold_req = 1'b1;
         random_request(allow_double);
      end
      req_tvalid <= 1'b0;
      drain();
   endtask

   // Both registers, one per cycle; the model follows at the write edge
   task automatic write_regs(input logic [12:0] cap, input logic [12:0] slot);
      csr_we    <= 1'b1;
      csr_index <= REG_ARENA_CAPACITY;
      csr_wdata <= cap;
      @(posedge clock);
      cap_reg   = cap;
      csr_index <= REG_SLOT_SIZE;
      csr_wdata <= slot;
      @(posedge clock);
      slot_reg  = slot[ADDR_W-1:0];
      csr_we    <= 1'b0;
   endtask

   // Main sequence
   initial begin
      for (int i = 0; i < LINK_DEPTH; i++)
         list_refs[i] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PROBE_ROWS; i++)
         send_request(probe_rows[i].cmd, probe_rows[i].amount, probe_rows[i].position,
                      probe_rows[i].typed, probe_rows[i].want);
      run_phase(PHASE_ITEMS, 60, 1'b0);

      write_regs(13'd8191, 13'd1);
      run_phase(PHASE_ITEMS, -1, 1'b0);
      write_regs(13'd0, 13'd0);
      run_phase(PHASE_ITEMS, -1, 1'b0);
      write_regs(13'd1, 13'h1FFF);
      run_phase(PHASE_ITEMS, -1, 1'b0);
      write_regs(13'd600, 13'd40);
      run_phase(PHASE_ITEMS, -1, 1'b0);
      write_regs(13'd2048, 13'd4095);
      run_phase(PHASE_ITEMS, -1, 1'b0);

      // last stretch: no idling, repeated frees allowed
      write_regs(13'd4096, 13'd24);
      calm = 1'b1;
      run_phase(PHASE_ITEMS, -1, 1'b1);

      if (mismatches == 0 && owed_results.size() == 0)
         $display("tb_bump_allocator_with_free_list_unit: done, clean");
      else
         $display("tb_bump_allocator_with_free_list_unit: done, errors");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      int rx_gap;
      hold_left = 0;
      rx_gap    = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 15) == 0) begin
            rx_gap = $urandom_range(0, 16);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Result check against the oldest owed result
   always @(posedge clock) begin : result_check
      arena_result_t want;
      arena_result_t seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.granted   = rsp_tdata[0];
         seen.address   = rsp_tdata[12:1];
         seen.from_list = rsp_tdata[13];
         seen.used      = rsp_tdata[25:14];
         if (owed_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: granted %0b addr %0d list %0b used %0d",
                        seen.granted, seen.address, seen.from_list, seen.used);
         end else begin
            want = owed_results.pop_front();
            if (seen.granted !== want.granted || seen.address !== want.address ||
                seen.from_list !== want.from_list || seen.used !== want.used) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: exp granted %0b addr %0d list %0b used %0d, got granted %0b addr %0d list %0b used %0d",
                           want.granted, want.address, want.from_list, want.used,
                           seen.granted, seen.address, seen.from_list, seen.used);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_bump_allocator_with_free_list_unit: done, errors");
         $finish;
      end
   end

endmodule
